@@ rtl/sensor_advert_object_parser_macros.svh @@
// Assertion helpers shared by the parser RTL.
`ifndef SENSOR_ADVERT_OBJECT_PARSER_MACROS_SVH
`define SENSOR_ADVERT_OBJECT_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge out of reset
`define SAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication
`define SAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define SAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/sap_pkg.sv @@
package sap_pkg;

	// One payload byte with its packet marks
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_packet;
		logic       last_of_packet;
		logic [7:0] packet_length;
	} item_t;

	// One result beat
	typedef struct packed {
		logic              result_kind;
		logic [3:0]        sensor_kind;
		logic signed [24:0] raw_value;
		logic [1:0]        scale_code;
		logic [4:0]        reading_index;
		logic [1:0]        packet_status;
		logic              last_result;
	} result_t;

	// Object table row
	typedef struct packed {
		logic [7:0] id;
		logic [3:0] kind;
		logic [1:0] scale;
		logic [1:0] size;
		logic       sgn;
	} obj_row_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] entry;
	} lookup_t;

	localparam logic KIND_READING = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [1:0] ST_READINGS  = 2'd0;
	localparam logic [1:0] ST_NONE      = 2'd1;
	localparam logic [1:0] ST_VERSION   = 2'd2;
	localparam logic [1:0] ST_ENCRYPTED = 2'd3;

	localparam logic [7:0] VER_MASK       = 8'hC0;
	localparam logic [7:0] VER_2          = 8'h40;
	localparam logic [7:0] FLAG_ENCRYPTED = 8'h01;
	localparam logic [7:0] FLAG_MAC       = 8'h08;
	localparam logic [7:0] BIN_FIRST      = 8'h0F;
	localparam logic [7:0] BIN_LAST       = 8'h2D;
	localparam logic [2:0] MAC_LEN        = 3'd6;
	localparam logic [7:0] MAC_MIN_LEN    = 8'd7;

	localparam int OBJ_COUNT = 12;
	localparam obj_row_t OBJ_TABLE [OBJ_COUNT] = '{
		'{8'h01, 4'd0, 2'd0, 2'd1, 1'b0},
		'{8'h02, 4'd1, 2'd2, 2'd2, 1'b1},
		'{8'h03, 4'd2, 2'd2, 2'd2, 1'b0},
		'{8'h04, 4'd3, 2'd2, 2'd3, 1'b0},
		'{8'h05, 4'd4, 2'd2, 2'd3, 1'b0},
		'{8'h08, 4'd1, 2'd2, 2'd2, 1'b1},
		'{8'h2E, 4'd2, 2'd0, 2'd1, 1'b0},
		'{8'h44, 4'd5, 2'd2, 2'd2, 1'b0},
		'{8'h45, 4'd1, 2'd1, 2'd2, 1'b1},
		'{8'h46, 4'd9, 2'd1, 2'd1, 1'b0},
		'{8'h5E, 4'd7, 2'd2, 2'd2, 1'b0},
		'{8'h5F, 4'd8, 2'd1, 2'd2, 1'b0}
	};

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Match an object id against the table; first match wins
	function automatic lookup_t obj_lookup(input logic [7:0] id);
		lookup_t r;
		r = '0;
		for (int i = OBJ_COUNT - 1; i >= 0; i--) begin
			if (OBJ_TABLE[i].id == id) begin
				r.hit = 1'b1;
				r.entry = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/sensor_advert_object_parser.sv @@
// Sensor advertisement object parser. Takes one service-data byte per beat and
// sustains one byte per cycle: each byte is registered, parsed by a table
// compare and a shift-in once the queue has room, and its results are written to a
// four-entry result queue that drives the output port. A byte yields zero, one
// or two results (a final reading plus the packet status). The input stalls
// only while a byte waits in the input register and the queue has fewer than
// two free entries, so with the output stalled the input is held up once three
// results are waiting. A byte's results pass through the input register and
// the result queue on their way to the output port. Readings carry the raw
// integer and a decimal scale code; encrypted packets are reported by status
// only.
module sensor_advert_object_parser import sap_pkg::*; #(
	parameter int MAX_READINGS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               first_of_packet,
	input  logic               last_of_packet,
	input  logic [7:0]         packet_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [3:0]         sensor_kind,
	output logic signed [24:0] raw_value,
	output logic [1:0]         scale_code,
	output logic [4:0]         reading_index,
	output logic [1:0]         packet_status,
	output logic               last_result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    room;
	logic    advance;
	logic    accept;
	logic    push_a;
	logic    push_b;
	result_t res_a;
	result_t res_b;
	result_t dout;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// Input stage: hold a beat until the queue can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{data_byte, first_of_packet, last_of_packet, packet_length};
		end
	end

	sap_core #(
		.MAX_READINGS(MAX_READINGS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.push_a (push_a),
		.push_b (push_b),
		.res_a  (res_a),
		.res_b  (res_b)
	);

	sap_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.din_a     (res_a),
		.din_b     (res_b),
		.pop       (out_valid && !out_stall),
		.room      (room),
		.dout_valid(out_valid),
		.dout      (dout)
	);

	assign result_kind   = dout.result_kind;
	assign sensor_kind   = dout.sensor_kind;
	assign raw_value     = dout.raw_value;
	assign scale_code    = dout.scale_code;
	assign reading_index = dout.reading_index;
	assign packet_status = dout.packet_status;
	assign last_result   = dout.last_result;

endmodule

@@ rtl/sap_core.sv @@
module sap_core import sap_pkg::*; #(
	parameter int MAX_READINGS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	output logic    push_a,
	output logic    push_b,
	output result_t res_a,
	output result_t res_b
);

	localparam int SEEN_W = $clog2(MAX_READINGS + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MAC,
		PH_ID,
		PH_VALUE,
		PH_BIN
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [7:0]          pos_q, pos_n;
	logic [2:0]          mac_q, mac_n;
	logic [3:0]          entry_q, entry_n;
	logic [1:0]          left_q, left_n;
	logic [23:0]         acc_q, acc_n;
	logic [SEEN_W-1:0]   seen_q, seen_n;
	logic                stop_q, stop_n;
	logic [1:0]          hdr_q, hdr_n;

	logic                rd_hit;
	logic                st_hit;
	result_t             rd_res;
	result_t             st_res;
	lookup_t             lk;
	obj_row_t            row;
	obj_row_t            row_l;
	logic [1:0]          off;
	logic [24:0]         ext;
	logic [7:0]          b;
	logic [7:0]          len;
	logic                live;

	// Parse one byte: next state and the results it causes
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		mac_n   = mac_q;
		entry_n = entry_q;
		left_n  = left_q;
		acc_n   = acc_q;
		seen_n  = seen_q;
		stop_n  = stop_q;
		hdr_n   = hdr_q;
		rd_hit  = 1'b0;
		st_hit  = 1'b0;
		rd_res  = '0;
		st_res  = '0;
		ext     = '0;
		b       = item.data_byte;
		len     = item.packet_length;
		lk      = obj_lookup(b);
		row     = OBJ_TABLE[entry_q];
		row_l   = OBJ_TABLE[lk.entry];
		off     = 2'(row.size - left_q);
		live    = item.first_of_packet || (phase_q != PH_IDLE);

		if (item.first_of_packet) begin
			// Device-info byte: reset the packet and check the header
			pos_n   = 8'd1;
			mac_n   = '0;
			entry_n = '0;
			left_n  = '0;
			acc_n   = '0;
			seen_n  = '0;
			stop_n  = 1'b0;
			hdr_n   = ST_READINGS;
			phase_n = PH_ID;
			if ((b & VER_MASK) != VER_2) begin
				hdr_n  = ST_VERSION;
				stop_n = 1'b1;
			end else if ((b & FLAG_ENCRYPTED) != 8'd0) begin
				hdr_n  = ST_ENCRYPTED;
				stop_n = 1'b1;
			end else if (((b & FLAG_MAC) != 8'd0) && (len >= MAC_MIN_LEN)) begin
				phase_n = PH_MAC;
				mac_n   = MAC_LEN;
			end
		end else if (phase_q != PH_IDLE) begin
			if (!stop_q && (pos_q < len)) begin
				case (phase_q)
					PH_MAC: begin
						mac_n = mac_q - 3'd1;
						if (mac_n == 3'd0) begin
							phase_n = PH_ID;
						end
					end
					PH_ID: begin
						if (seen_q >= SEEN_W'(MAX_READINGS)) begin
							stop_n = 1'b1;
						end else if (lk.hit) begin
							// Drop an object whose value would run past the packet
							if (({2'b00, pos_q} + 10'd1 + 10'(row_l.size)) > {2'b00, len}) begin
								stop_n = 1'b1;
							end else begin
								entry_n = lk.entry;
								left_n  = row_l.size;
								acc_n   = '0;
								phase_n = PH_VALUE;
							end
						end else if ((b >= BIN_FIRST) && (b <= BIN_LAST)) begin
							phase_n = PH_BIN;
						end else begin
							stop_n = 1'b1;
						end
					end
					PH_VALUE: begin
						// Shift in the next little-endian byte
						if (off != 2'd3) begin
							acc_n = acc_q | (24'(b) << {off, 3'b000});
						end
						left_n = left_q - 2'd1;
						if (left_n == 2'd0) begin
							case (row.size)
								2'd1: ext = {{17{row.sgn & acc_n[7]}}, acc_n[7:0]};
								2'd2: ext = {{9{row.sgn & acc_n[15]}}, acc_n[15:0]};
								default: ext = {row.sgn & acc_n[23], acc_n};
							endcase
							rd_hit = 1'b1;
							rd_res.result_kind   = KIND_READING;
							rd_res.sensor_kind   = row.kind;
							rd_res.raw_value     = ext;
							rd_res.scale_code    = row.scale;
							rd_res.reading_index = 5'(seen_q);
							rd_res.packet_status = ST_READINGS;
							seen_n  = seen_q + SEEN_W'(1);
							phase_n = PH_ID;
						end
					end
					PH_BIN: begin
						phase_n = PH_ID;
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
			if (pos_q != 8'hFF) begin
				pos_n = pos_q + 8'd1;
			end
		end

		// Close the packet with a status beat
		if (item.last_of_packet && live) begin
			st_hit = 1'b1;
			st_res.result_kind   = KIND_STATUS;
			st_res.packet_status = (hdr_n != ST_READINGS) ? hdr_n :
				((seen_n != '0) ? ST_READINGS : ST_NONE);
			st_res.last_result   = 1'b1;
			phase_n = PH_IDLE;
		end
		rd_res.last_result = !st_hit;
	end

	// Pack results into queue slots in order
	always_comb begin
		push_a = advance && (rd_hit || st_hit);
		push_b = advance && rd_hit && st_hit;
		res_a  = rd_hit ? rd_res : st_res;
		res_b  = st_res;
	end

	// Hold parser state; advance on each byte taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			mac_q   <= '0;
			entry_q <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			seen_q  <= '0;
			stop_q  <= 1'b0;
			hdr_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			mac_q   <= mac_n;
			entry_q <= entry_n;
			left_q  <= left_n;
			acc_q   <= acc_n;
			seen_q  <= seen_n;
			stop_q  <= stop_n;
			hdr_q   <= hdr_n;
		end
	end

endmodule

@@ rtl/sap_result_fifo.sv @@
module sap_result_fifo import sap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_a,
	input  logic    push_b,
	input  result_t din_a,
	input  result_t din_b,
	input  logic    pop,
	output logic    room,
	output logic    dout_valid,
	output result_t dout
);

`include "sensor_advert_object_parser_macros.svh"

	result_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_push;

	assign n_push     = CNT_W'(push_a) + CNT_W'(push_b);
	assign room       = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign dout_valid = count_q != '0;
	assign dout       = mem[rd_q];

	// Write up to two beats per cycle
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem[wr_q] <= din_a;
		end
		if (push_b) begin
			mem[wr_q + PTR_W'(1)] <= din_b;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	`SAP_ASSERT_IMP(a_no_overflow, clk, arst_n, 1'b1, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`SAP_ASSERT_IMP(a_push_order, clk, arst_n, push_b, push_a, "second slot pushed without first")
	`SAP_ASSERT_IMP(a_push_room, clk, arst_n, push_a, room, "push without two free slots")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import sap_pkg::*;

	localparam int READ_LIMIT   = 16;
	localparam int PHASE_BEATS  = 455;
	localparam int DRAIN_CYCLES = 10;
	localparam int QUIET_LIMIT  = 2000;

	// Object ids of the known table
	localparam logic [7:0] ID_BATTERY  = 8'h01;
	localparam logic [7:0] ID_TEMP     = 8'h02;
	localparam logic [7:0] ID_HUMID    = 8'h03;
	localparam logic [7:0] ID_PRESSURE = 8'h04;
	localparam logic [7:0] ID_ILLUM    = 8'h05;
	localparam logic [7:0] ID_TEMP_B   = 8'h08;
	localparam logic [7:0] ID_HUMID_B  = 8'h2E;
	localparam logic [7:0] ID_WIND     = 8'h44;
	localparam logic [7:0] ID_TEMP_C   = 8'h45;
	localparam logic [7:0] ID_UV       = 8'h46;
	localparam logic [7:0] ID_DIR      = 8'h5E;
	localparam logic [7:0] ID_RAIN     = 8'h5F;
	localparam logic [7:0] ID_UNKNOWN  = 8'hC3;

	localparam logic [7:0] KNOWN_IDS [12] = '{ID_BATTERY, ID_TEMP, ID_HUMID, ID_PRESSURE,
		ID_ILLUM, ID_TEMP_B, ID_HUMID_B, ID_WIND, ID_TEMP_C, ID_UV, ID_DIR, ID_RAIN};

	// Sensor kinds carried by readings
	localparam logic [3:0] SK_BATTERY  = 4'd0;
	localparam logic [3:0] SK_TEMP     = 4'd1;
	localparam logic [3:0] SK_HUMID    = 4'd2;
	localparam logic [3:0] SK_PRESSURE = 4'd3;
	localparam logic [3:0] SK_ILLUM    = 4'd4;
	localparam logic [3:0] SK_WIND     = 4'd5;
	localparam logic [3:0] SK_DIR      = 4'd7;
	localparam logic [3:0] SK_RAIN     = 4'd8;
	localparam logic [3:0] SK_UV       = 4'd9;

	typedef enum {P_IDLE, P_SKIP_ADDR, P_OBJ_ID, P_OBJ_VALUE, P_BINARY} parse_state_t;

	typedef struct {
		logic [3:0] kind;
		logic [1:0] scale;
		int         size;
		bit         sgn;
	} obj_desc_t;

	// Describe a known object id; return 0 for anything else
	function automatic bit lookup_object(input logic [7:0] id, output obj_desc_t d);
		d = '{SK_BATTERY, 2'd0, 1, 1'b0};
		case (id)
		ID_BATTERY:  d = '{SK_BATTERY, 2'd0, 1, 1'b0};
		ID_TEMP:     d = '{SK_TEMP, 2'd2, 2, 1'b1};
		ID_HUMID:    d = '{SK_HUMID, 2'd2, 2, 1'b0};
		ID_PRESSURE: d = '{SK_PRESSURE, 2'd2, 3, 1'b0};
		ID_ILLUM:    d = '{SK_ILLUM, 2'd2, 3, 1'b0};
		ID_TEMP_B:   d = '{SK_TEMP, 2'd2, 2, 1'b1};
		ID_HUMID_B:  d = '{SK_HUMID, 2'd0, 1, 1'b0};
		ID_WIND:     d = '{SK_WIND, 2'd2, 2, 1'b0};
		ID_TEMP_C:   d = '{SK_TEMP, 2'd1, 2, 1'b1};
		ID_UV:       d = '{SK_UV, 2'd1, 1, 1'b0};
		ID_DIR:      d = '{SK_DIR, 2'd2, 2, 1'b0};
		ID_RAIN:     d = '{SK_RAIN, 2'd1, 2, 1'b0};
		default:     return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic string show(result_t r);
		return $sformatf("kind=%0d sensor=%0d raw=%0d scale=%0d index=%0d status=%0d last=%0d",
			r.result_kind, r.sensor_kind, r.raw_value, r.scale_code, r.reading_index,
			r.packet_status, r.last_result);
	endfunction

	// Parser mirror plus the queue of readings and statuses still owed
	class parse_scoreboard;
		result_t      expected_q[$];
		int           errors;
		parse_state_t phase;
		int           pos;
		int           mac_left;
		obj_desc_t    cur;
		int           bytes_left;
		logic [23:0]  acc;
		int           readings;
		bit           stopped;
		logic [1:0]   hdr_status;

		function new();
			errors = 0;
			phase = P_IDLE;
			clear();
		endfunction

		function void clear();
			pos = 0;
			mac_left = 0;
			cur = '{SK_BATTERY, 2'd0, 1, 1'b0};
			bytes_left = 0;
			acc = '0;
			readings = 0;
			stopped = 1'b0;
			hdr_status = ST_READINGS;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// Advance the mirror by one accepted byte and queue what it yields
		function void note_byte(item_t it);
			logic [7:0]  b;
			int          len;
			int          owed;
			obj_desc_t   d;
			result_t     r;
			logic [24:0] raw;
			b = it.data_byte;
			len = it.packet_length;
			owed = expected_q.size();
			if (it.first_of_packet) begin
				// open a new packet, dropping any open one
				clear();
				pos = 1;
				phase = P_OBJ_ID;
				if ((b & VER_MASK) != VER_2) begin
					hdr_status = ST_VERSION;
					stopped = 1'b1;
				end else if ((b & FLAG_ENCRYPTED) != 0) begin
					hdr_status = ST_ENCRYPTED;
					stopped = 1'b1;
				end else if ((b & FLAG_MAC) != 0 && len >= MAC_MIN_LEN) begin
					phase = P_SKIP_ADDR;
					mac_left = MAC_LEN;
				end
			end else begin
				// drop bytes outside a packet
				if (phase == P_IDLE)
					return;
				if (!stopped && pos < len) begin
					case (phase)
					P_SKIP_ADDR: begin
						mac_left--;
						if (mac_left == 0)
							phase = P_OBJ_ID;
					end
					P_OBJ_ID: begin
						if (readings >= READ_LIMIT) begin
							stopped = 1'b1;
						end else if (lookup_object(b, d)) begin
							if (pos + 1 + d.size > len) begin
								stopped = 1'b1;
							end else begin
								cur = d;
								bytes_left = d.size;
								acc = '0;
								phase = P_OBJ_VALUE;
							end
						end else if (b >= BIN_FIRST && b <= BIN_LAST) begin
							phase = P_BINARY;
						end else begin
							stopped = 1'b1;
						end
					end
					P_OBJ_VALUE: begin
						// shift in little-endian, emit when the value is whole
						acc = acc | (24'(b) << (8 * (cur.size - bytes_left)));
						bytes_left--;
						if (bytes_left == 0) begin
							raw = 25'(acc);
							if (cur.sgn && acc[8 * cur.size - 1])
								for (int i = 8 * cur.size; i < 25; i++)
									raw[i] = 1'b1;
							r = '0;
							r.result_kind = KIND_READING;
							r.sensor_kind = cur.kind;
							r.raw_value = raw;
							r.scale_code = cur.scale;
							r.reading_index = 5'(readings);
							r.packet_status = ST_READINGS;
							expected_q.push_back(r);
							readings++;
							phase = P_OBJ_ID;
						end
					end
					P_BINARY: phase = P_OBJ_ID;
					default: ;
					endcase
				end
				if (pos < 255)
					pos++;
			end
			// close the packet with its status
			if (it.last_of_packet) begin
				r = '0;
				r.result_kind = KIND_STATUS;
				if (hdr_status != ST_READINGS)
					r.packet_status = hdr_status;
				else
					r.packet_status = (readings > 0) ? ST_READINGS : ST_NONE;
				expected_q.push_back(r);
				phase = P_IDLE;
			end
			if (expected_q.size() > owed)
				expected_q[expected_q.size() - 1].last_result = 1'b1;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				flag({"unexpected result: ", show(got)});
				return;
			end
			want = expected_q.pop_front();
			if (got.result_kind !== want.result_kind || got.sensor_kind !== want.sensor_kind ||
					got.raw_value !== want.raw_value || got.scale_code !== want.scale_code ||
					got.reading_index !== want.reading_index ||
					got.packet_status !== want.packet_status ||
					got.last_result !== want.last_result)
				flag({"result mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	item_t              beat = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               result_kind;
	logic [3:0]         sensor_kind;
	logic signed [24:0] raw_value;
	logic [1:0]         scale_code;
	logic [4:0]         reading_index;
	logic [1:0]         packet_status;
	logic               last_result;

	parse_scoreboard sb;
	item_t           beat_q[$];
	int              idle_pct = 0;
	int              stall_pct = 0;
	int              quiet_cycles = 0;

	sensor_advert_object_parser #(.MAX_READINGS(READ_LIMIT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(beat.data_byte),
		.first_of_packet(beat.first_of_packet),
		.last_of_packet(beat.last_of_packet),
		.packet_length(beat.packet_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.sensor_kind(sensor_kind),
		.raw_value(raw_value),
		.scale_code(scale_code),
		.reading_index(reading_index),
		.packet_status(packet_status),
		.last_result(last_result)
	);

	always #1 clk = ~clk;

	// Stall the result side at random
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// Track accepted beats on both sides
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(beat);
			if (out_valid && !out_stall)
				sb.check_result({result_kind, sensor_kind, raw_value, scale_code,
					reading_index, packet_status, last_result});
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	function automatic void add_beat(logic [7:0] data, bit first, bit last, logic [7:0] len);
		item_t it;
		it.data_byte = data;
		it.first_of_packet = first;
		it.last_of_packet = last;
		it.packet_length = len;
		beat_q.push_back(it);
	endfunction

	// Queue one random packet: mostly well formed, some noise and broken framing
	function automatic void add_packet();
		logic [7:0] body[$];
		logic [7:0] hdr;
		logic [7:0] id;
		obj_desc_t  d;
		int         sel;
		int         pick;
		int         nobj;
		int         len;
		bit         open_end;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			repeat ($urandom_range(2, 8))
				add_beat(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
					8'($urandom_range(1, 255)));
			return;
		end
		if (sel < 13)
			hdr = 8'($urandom);
		else if (sel < 18)
			hdr = VER_2 | FLAG_ENCRYPTED | (8'($urandom) & 8'h3E);
		else
			hdr = VER_2 | (8'($urandom) & 8'h3E);
		body.push_back(hdr);
		if ((hdr & FLAG_MAC) != 0)
			repeat (MAC_LEN)
				body.push_back(8'($urandom));
		nobj = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 6);
		repeat (nobj) begin
			sel = $urandom_range(0, 99);
			if (sel < 85) begin
				id = KNOWN_IDS[$urandom_range(0, 11)];
				void'(lookup_object(id, d));
				body.push_back(id);
				repeat (d.size) begin
					pick = $urandom_range(0, 5);
					body.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF :
						pick == 2 ? 8'h80 : 8'($urandom));
				end
			end else if (sel < 97) begin
				body.push_back(8'($urandom_range(BIN_FIRST, BIN_LAST)));
				body.push_back(8'($urandom));
			end else begin
				do
					id = 8'($urandom);
				while (lookup_object(id, d) || (id >= BIN_FIRST && id <= BIN_LAST));
				body.push_back(id);
				body.push_back(8'($urandom));
			end
		end
		// declared length: exact, short, long or arbitrary
		len = body.size();
		sel = $urandom_range(0, 99);
		if (sel < 8)
			len = (len > 3) ? len - $urandom_range(1, 3) : 1;
		else if (sel < 14)
			len = (len + 3 > 255) ? 255 : len + $urandom_range(1, 3);
		else if (sel < 17)
			len = $urandom_range(1, 255);
		open_end = ($urandom_range(0, 24) == 0);
		foreach (body[i])
			add_beat(body[i], i == 0, (i == body.size() - 1) && !open_end, 8'(len));
	endfunction

	// Present one beat, idling first at random, and hold it until taken
	task automatic send_beat(item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		beat <= it;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Hold the input until every owed result is out
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// byte outside any packet, even with the end mark
		add_beat(8'hFF, 0, 1, 8'd255);
		// header-only packets: wrong version, encrypted
		add_beat(8'h00, 1, 1, 8'd1);
		add_beat(VER_2 | FLAG_ENCRYPTED, 1, 1, 8'd1);
		// address skip, then a negative temperature ending on the last byte
		add_beat(VER_2 | FLAG_MAC, 1, 0, 8'd10);
		foreach (KNOWN_IDS[i])
			if (i < MAC_LEN)
				add_beat(8'hAA ^ 8'(i * 37), 0, 0, 8'd10);
		add_beat(ID_TEMP, 0, 0, 8'd10);
		add_beat(8'hFF, 0, 0, 8'd10);
		add_beat(8'hFF, 0, 1, 8'd10);
		// widest unsigned value, a binary object, an unknown id
		add_beat(VER_2, 1, 0, 8'd8);
		add_beat(ID_PRESSURE, 0, 0, 8'd8);
		repeat (3)
			add_beat(8'hFF, 0, 0, 8'd8);
		add_beat(BIN_LAST, 0, 0, 8'd8);
		add_beat(8'h80, 0, 0, 8'd8);
		add_beat(ID_UNKNOWN, 0, 1, 8'd8);
		// restart mid-packet into a header-only packet of length zero
		add_beat(VER_2, 1, 0, 8'd5);
		add_beat(ID_TEMP_C, 0, 0, 8'd5);
		add_beat(VER_2 | 8'h06, 1, 1, 8'd0);
		// early end while a value is being gathered
		add_beat(VER_2, 1, 0, 8'd6);
		add_beat(ID_TEMP_C, 0, 0, 8'd6);
		add_beat(8'h12, 0, 1, 8'd6);
		while (beat_q.size() != 0)
			send_beat(beat_q.pop_front());
		settle();

		// random packets under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 50; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 50; end
			default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			while (beat_q.size() < PHASE_BEATS)
				add_packet();
			while (beat_q.size() != 0)
				send_beat(beat_q.pop_front());
			settle();
		end

		if (sb.expected_q.size() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
